>>> rtl/bti_pkg.sv
package bti_pkg;

  localparam int unsigned CFG_TABLES = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ROW    = 2'd1,
    KIND_COL    = 2'd2,
    KIND_ENTRY  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  tsel;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] data;
    logic [31:0] qr;
    logic [31:0] qc;
    logic        oor;
  } item_t;

endpackage

>>> rtl/bilinear_table_interpolator.sv
// Channel  Direction  Handshake              Beat
// in       input      in_valid_i/in_ready_o  kind, table, indices, write value, queries
// out      output     out_valid_o/out_ready_i value, in_range
// cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// Writes retire at the head of the two-beat queue once the sequencer is idle.
// A lookup's duration is set by the breakpoint scan through one RAM read port per axis
// and the bit-serial weight division.
// Reset clears the queue, sequencer and count registers; the stores are not cleared.
// A stalled output holds the result while the queue accepts beats until it is full.
module bilinear_table_interpolator #(
  parameter int unsigned NUM_TABLES = 4,
  parameter int unsigned MAX_ROWS   = 16,
  parameter int unsigned MAX_COLS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [1:0]                    table_select_i,
  input  logic [3:0]                    row_index_i,
  input  logic [3:0]                    col_index_i,
  input  logic [31:0]                   write_value_i,
  input  logic [31:0]                   query_row_i,
  input  logic [31:0]                   query_col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   value_o,
  output logic                          in_range_o,
  input  logic                          cfg_we_i,
  input  logic [bti_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bti_pkg::CNT_W-1:0]     cfg_data_i
);

  logic           q_valid, q_pop;
  bti_pkg::item_t q_item;

  bti_front #(
    .NUM_TABLES (NUM_TABLES),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .table_select_i (table_select_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .write_value_i  (write_value_i),
    .query_row_i    (query_row_i),
    .query_col_i    (query_col_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  bti_back #(
    .NUM_TABLES (NUM_TABLES),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .in_range_o  (in_range_o)
  );

endmodule

>>> rtl/bti_ram.sv
module bti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/bti_front.sv
module bti_front #(
  parameter int unsigned NUM_TABLES = 4,
  parameter int unsigned MAX_ROWS   = 16,
  parameter int unsigned MAX_COLS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [1:0]          table_select_i,
  input  logic [3:0]          row_index_i,
  input  logic [3:0]          col_index_i,
  input  logic [31:0]         write_value_i,
  input  logic [31:0]         query_row_i,
  input  logic [31:0]         query_col_i,
  output logic                q_valid_o,
  output bti_pkg::item_t      q_item_o,
  input  logic                q_pop_i
);

  bti_pkg::item_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  bti_pkg::item_t item;
  logic           push, drop, pop, bad_t, bad_r, bad_c;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rptr_q];
  assign pop        = q_pop_i && q_valid_o;

  assign bad_t = (32'(table_select_i) >= NUM_TABLES);
  assign bad_r = (32'(row_index_i) >= MAX_ROWS);
  assign bad_c = (32'(col_index_i) >= MAX_COLS);

  always_comb begin
    item.kind = bti_pkg::kind_e'(kind_i);
    item.tsel = table_select_i;
    item.row  = row_index_i;
    item.col  = col_index_i;
    item.data = write_value_i;
    item.qr   = query_row_i;
    item.qc   = query_col_i;
    item.oor  = bad_t;
    unique case (item.kind)
      bti_pkg::KIND_LOOKUP: drop = 1'b0;
      bti_pkg::KIND_ROW:    drop = bad_t || bad_r;
      bti_pkg::KIND_COL:    drop = bad_t || bad_c;
      bti_pkg::KIND_ENTRY:  drop = bad_t || bad_r || bad_c;
      default:              drop = 1'b1;
    endcase
  end

  assign push = in_valid_i && in_ready_o && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        mem_q[wptr_q] <= item;
        wptr_q        <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/bti_back.sv
module bti_back #(
  parameter int unsigned NUM_TABLES = 4,
  parameter int unsigned MAX_ROWS   = 16,
  parameter int unsigned MAX_COLS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bti_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bti_pkg::CNT_W-1:0]         cfg_data_i,
  input  logic                              q_valid_i,
  input  bti_pkg::item_t                    q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [31:0]                       value_o,
  output logic                              in_range_o
);

  localparam int unsigned RD  = NUM_TABLES * MAX_ROWS;
  localparam int unsigned CD  = NUM_TABLES * MAX_COLS;
  localparam int unsigned ED  = NUM_TABLES * MAX_ROWS * MAX_COLS;
  localparam int unsigned RAW = $clog2(RD);
  localparam int unsigned CAW = $clog2(CD);
  localparam int unsigned EAW = $clog2(ED);

  typedef enum logic [2:0] {
    S_IDLE, S_SRD, S_SCK, S_DIV, S_ERD, S_EMUL, S_EACC, S_OUT
  } state_e;

  state_e                    state_q;
  logic [bti_pkg::CNT_W-1:0] rows_q [bti_pkg::CFG_TABLES];
  logic [bti_pkg::CNT_W-1:0] cols_q [bti_pkg::CFG_TABLES];
  bti_pkg::item_t            itm_q;
  logic                      axis_q, found_q;
  logic [bti_pkg::CNT_W-1:0] n_q, k_q, kaddr;
  logic [bti_pkg::CNT_W-1:0] idx_q [2];
  logic signed [31:0]        last_q, first_q, prev_q, a_q, b_q;
  logic [31:0]               rem_hi_q, rem_lo_q, dv_q;
  logic [16:0]               quo_hi_q, quo_lo_q;
  logic [4:0]                j_q;
  logic [16:0]               wlo_q [2];
  logic [16:0]               whi_q [2];
  logic [1:0]                c_q;
  logic [32:0]               wprod_q;
  logic signed [49:0]        ph_q;
  logic [48:0]               pl_q;
  logic [65:0]               acc_q, acc_d;
  logic [31:0]               res_val_q;
  logic                      res_rng_q;

  logic                      pop;
  logic [bti_pkg::CNT_W-1:0] n_rows, n_cols;
  logic signed [31:0]        rb_rdata, cb_rdata, en_rdata, cur, q;
  logic [RAW-1:0]            rb_waddr, rb_raddr;
  logic [CAW-1:0]            cb_waddr, cb_raddr;
  logic [EAW-1:0]            en_waddr, en_raddr;
  logic                      hit, last_k;
  logic [32:0]               rs_hi, rs_lo, dv_ext;
  logic                      ge_hi, ge_lo;
  logic [32:0]               nr_hi, nr_lo;
  logic [16:0]               wr, wc;
  logic signed [15:0]        eh;
  logic [15:0]               el;
  logic [1:0]                tq;

  assign pop     = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o = pop;
  assign tq      = pop ? q_item_i.tsel : itm_q.tsel;

  always_comb begin
    if (32'(rows_q[tq]) > MAX_ROWS) begin
      n_rows = bti_pkg::CNT_W'(MAX_ROWS);
    end else begin
      n_rows = rows_q[tq];
    end
    if (32'(cols_q[tq]) > MAX_COLS) begin
      n_cols = bti_pkg::CNT_W'(MAX_COLS);
    end else begin
      n_cols = cols_q[tq];
    end
  end

  assign rb_waddr = RAW'(32'(q_item_i.tsel) * MAX_ROWS + 32'(q_item_i.row));
  assign cb_waddr = CAW'(32'(q_item_i.tsel) * MAX_COLS + 32'(q_item_i.col));
  assign en_waddr = EAW'((32'(q_item_i.tsel) * MAX_ROWS + 32'(q_item_i.row)) * MAX_COLS
                         + 32'(q_item_i.col));

  assign kaddr    = (k_q == '0) ? n_q - 1'b1 : k_q - 1'b1;
  assign rb_raddr = RAW'(32'(itm_q.tsel) * MAX_ROWS + 32'(kaddr));
  assign cb_raddr = CAW'(32'(itm_q.tsel) * MAX_COLS + 32'(kaddr));
  assign en_raddr = EAW'((32'(itm_q.tsel) * MAX_ROWS + 32'(idx_q[0])) * MAX_COLS
                         + 32'(idx_q[1]) + 32'(c_q[0]) * MAX_COLS + 32'(c_q[1]));

  bti_ram #(.WIDTH(32), .DEPTH(RD)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (pop && q_item_i.kind == bti_pkg::KIND_ROW),
    .waddr_i (rb_waddr),
    .wdata_i (q_item_i.data),
    .raddr_i (rb_raddr),
    .rdata_o (rb_rdata)
  );

  bti_ram #(.WIDTH(32), .DEPTH(CD)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (pop && q_item_i.kind == bti_pkg::KIND_COL),
    .waddr_i (cb_waddr),
    .wdata_i (q_item_i.data),
    .raddr_i (cb_raddr),
    .rdata_o (cb_rdata)
  );

  bti_ram #(.WIDTH(32), .DEPTH(ED)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (pop && q_item_i.kind == bti_pkg::KIND_ENTRY),
    .waddr_i (en_waddr),
    .wdata_i (q_item_i.data),
    .raddr_i (en_raddr),
    .rdata_o (en_rdata)
  );

  assign cur    = axis_q ? cb_rdata : rb_rdata;
  assign q      = axis_q ? $signed(itm_q.qc) : $signed(itm_q.qr);
  assign hit    = (k_q >= 5'd2) && !found_q && (q >= prev_q) && (q < cur);
  assign last_k = (k_q == n_q);

  assign dv_ext = {1'b0, dv_q};
  assign rs_hi  = (j_q == '0) ? {1'b0, rem_hi_q} : {rem_hi_q, 1'b0};
  assign rs_lo  = (j_q == '0) ? {1'b0, rem_lo_q} : {rem_lo_q, 1'b0};
  assign ge_hi  = (rs_hi >= dv_ext);
  assign ge_lo  = (rs_lo >= dv_ext);
  assign nr_hi  = ge_hi ? rs_hi - dv_ext : rs_hi;
  assign nr_lo  = ge_lo ? rs_lo - dv_ext : rs_lo;

  assign wr = c_q[0] ? whi_q[0] : wlo_q[0];
  assign wc = c_q[1] ? whi_q[1] : wlo_q[1];
  assign eh = en_rdata[31:16];
  assign el = en_rdata[15:0];

  assign acc_d = acc_q + {ph_q, 16'b0} + {17'b0, pl_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      value_o     <= '0;
      in_range_o  <= 1'b0;
      for (int i = 0; i < bti_pkg::CFG_TABLES; i++) begin
        rows_q[i] <= '0;
        cols_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i[0]) begin
          cols_q[cfg_idx_i[2:1]] <= cfg_data_i;
        end else begin
          rows_q[cfg_idx_i[2:1]] <= cfg_data_i;
        end
      end
      if (out_valid_o && out_ready_i && state_q != S_OUT) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop && q_item_i.kind == bti_pkg::KIND_LOOKUP) begin
            itm_q     <= q_item_i;
            res_val_q <= '0;
            res_rng_q <= 1'b0;
            axis_q    <= 1'b0;
            k_q       <= '0;
            found_q   <= 1'b0;
            n_q       <= n_rows;
            if (q_item_i.oor || n_rows < 5'd2) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_SRD;
            end
          end
        end
        S_SRD: begin
          state_q <= S_SCK;
        end
        S_SCK: begin
          if (k_q == '0) begin
            last_q <= cur;
          end
          if (k_q == 5'd1) begin
            first_q <= cur;
          end
          prev_q <= cur;
          if (hit) begin
            found_q     <= 1'b1;
            a_q         <= prev_q;
            b_q         <= cur;
            idx_q[axis_q] <= k_q - 5'd2;
          end
          if (last_k) begin
            if ((found_q || hit) && q >= first_q && q < last_q) begin
              rem_hi_q <= hit ? 32'(q - prev_q) : 32'(q - a_q);
              rem_lo_q <= hit ? 32'(cur - q) : 32'(b_q - q);
              dv_q     <= hit ? 32'(cur - prev_q) : 32'(b_q - a_q);
              j_q      <= '0;
              state_q  <= S_DIV;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_DIV: begin
          rem_hi_q <= nr_hi[31:0];
          rem_lo_q <= nr_lo[31:0];
          quo_hi_q <= {quo_hi_q[15:0], ge_hi};
          quo_lo_q <= {quo_lo_q[15:0], ge_lo};
          j_q      <= j_q + 1'b1;
          if (j_q == 5'd16) begin
            whi_q[axis_q] <= {quo_hi_q[15:0], ge_hi};
            wlo_q[axis_q] <= {quo_lo_q[15:0], ge_lo};
            if (!axis_q) begin
              axis_q  <= 1'b1;
              k_q     <= '0;
              found_q <= 1'b0;
              n_q     <= n_cols;
              state_q <= (n_cols < 5'd2) ? S_OUT : S_SRD;
            end else begin
              c_q     <= '0;
              acc_q   <= '0;
              state_q <= S_ERD;
            end
          end
        end
        S_ERD: begin
          wprod_q <= 33'(wr) * 33'(wc);
          state_q <= S_EMUL;
        end
        S_EMUL: begin
          ph_q    <= $signed({1'b0, wprod_q}) * eh;
          pl_q    <= 49'(wprod_q) * 49'(el);
          state_q <= S_EACC;
        end
        S_EACC: begin
          acc_q <= acc_d;
          if (c_q == 2'd3) begin
            res_val_q <= acc_d[63:32];
            res_rng_q <= 1'b1;
            state_q   <= S_OUT;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_ERD;
          end
        end
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            value_o     <= res_val_q;
            in_range_o  <= res_rng_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
